[rtl/chebyshev_series_evaluator_assert.svh]
// ----------------------------------------------------------------------------
// Chebyshev series evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CHEBYSHEV_SERIES_EVALUATOR_ASSERT_SVH
`define CHEBYSHEV_SERIES_EVALUATOR_ASSERT_SVH

// same-cycle implication
`define CSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cse_pkg.sv]
// ----------------------------------------------------------------------------
// cse_pkg
// Widths, codes, types and arithmetic helpers of the Chebyshev series engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

  localparam int MAX_COEFFS = 32;
  localparam int FRAC_BITS  = 16;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int CIDX_W  = 5;
  localparam int ORD_W   = 2;
  localparam int COUNT_W = 6;

  localparam int IDX_W   = $clog2(MAX_COEFFS);
  localparam int CNT_W   = $clog2(MAX_COEFFS + 1);
  localparam int BANKS   = 3;
  localparam int RAM_DEPTH = BANKS * MAX_COEFFS;
  localparam int ADDR_W  = $clog2(RAM_DEPTH);

  localparam int MUL_W   = DATA_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SUM_W   = PROD_W + 2;

  // input tdata layout, lowest field first
  localparam int TD_IDX_LSB = 0;
  localparam int TD_VAL_LSB = TD_IDX_LSB + CIDX_W;
  localparam int TD_X_LSB   = TD_VAL_LSB + DATA_W;
  localparam int TD_ORD_LSB = TD_X_LSB + DATA_W;
  localparam int TD_USED    = TD_ORD_LSB + ORD_W;
  localparam int IN_TDATA_W = ((TD_USED + 7) / 8) * 8;

  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_DERIVE = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

  localparam logic [ORD_W-1:0] ORD_FUNC  = 2'd0;
  localparam logic [ORD_W-1:0] ORD_FIRST = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd3;

  localparam logic signed [DATA_W-1:0] LOWER_RST = -32'sd65536;
  localparam logic signed [DATA_W-1:0] UPPER_RST = 32'sd65536;
  localparam logic signed [DATA_W-1:0] SCALE_RST = 32'sd65536;
  localparam logic [COUNT_W-1:0]       COUNT_RST = 6'd2;

  typedef logic [1:0] bank_t;

  localparam bank_t BANK_COEFF = 2'd0;
  localparam bank_t BANK_D1    = 2'd1;
  localparam bank_t BANK_D2    = 2'd2;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [CIDX_W-1:0]        idx;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] x;
    logic [ORD_W-1:0]         ord;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;
    logic signed [DATA_W-1:0] scale;
    logic [CNT_W-1:0]         n;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     error;
  } res_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = {1'b0, {(DATA_W - 1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input bank_t bank,
                                                 input logic [IDX_W-1:0] idx);
    return ADDR_W'(bank) * ADDR_W'(MAX_COEFFS) + ADDR_W'(idx);
  endfunction

endpackage

`default_nettype wire

[rtl/cse_ram.sv]
// ----------------------------------------------------------------------------
// cse_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 96,
  parameter int ADDR_W = 7
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/cse_engine.sv]
// ----------------------------------------------------------------------------
// cse_engine
// Sequencer and shared multiply datapath around the coefficient RAM:
// coefficient write, derivative table build, Clenshaw evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chebyshev_series_evaluator_assert.svh"

module cse_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start_i,
  input  wire cse_pkg::cmd_t cmd_i,
  input  wire cse_pkg::cfg_t cfg_i,
  output logic               idle_o,
  output logic               res_valid_o,
  output cse_pkg::res_t      res_o,
  input  wire logic          take_i
);

  localparam int DATA_W = cse_pkg::DATA_W;
  localparam int IDX_W  = cse_pkg::IDX_W;
  localparam int CNT_W  = cse_pkg::CNT_W;
  localparam int MUL_W  = cse_pkg::MUL_W;
  localparam int PROD_W = cse_pkg::PROD_W;
  localparam int SUM_W  = cse_pkg::SUM_W;
  localparam int ADDR_W = cse_pkg::ADDR_W;
  localparam int FB     = cse_pkg::FRAC_BITS;
  localparam int T_W    = DATA_W + 2;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MAP_MUL = 4'd1;
  localparam logic [3:0] ST_MAP_Y   = 4'd2;
  localparam logic [3:0] ST_EV_MUL  = 4'd3;
  localparam logic [3:0] ST_EV_ACC  = 4'd4;
  localparam logic [3:0] ST_DV_MUL  = 4'd5;
  localparam logic [3:0] ST_DV_ACC  = 4'd6;
  localparam logic [3:0] ST_DV_SCL  = 4'd7;
  localparam logic [3:0] ST_DV_WR   = 4'd8;
  localparam logic [3:0] ST_RES     = 4'd9;

  logic [3:0]                state_r, state_nxt;
  cse_pkg::bank_t            bank_r, bank_nxt;
  logic [IDX_W-1:0]          j_r, j_nxt;
  logic                      first_r, first_nxt;
  logic signed [MUL_W-1:0]   t_r, t_nxt;
  logic signed [DATA_W-1:0]  y_r, y_nxt;
  logic signed [DATA_W-1:0]  d_r, d_nxt;
  logic signed [DATA_W-1:0]  dd_r, dd_nxt;
  logic signed [DATA_W-1:0]  u1_r, u1_nxt;
  logic signed [DATA_W-1:0]  u2_r, u2_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DATA_W-1:0]  res_value_r, res_value_nxt;
  logic                      res_error_r, res_error_nxt;

  logic                      ram_we, ram_re;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [DATA_W-1:0]         ram_wdata, ram_rdata;
  logic signed [DATA_W-1:0]  rd_s;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic signed [T_W-1:0]     t_calc;
  logic                      out_of_range;
  logic signed [SUM_W-1:0]   ev_sum, dv_sum;
  logic signed [DATA_W-1:0]  scaled;
  logic [IDX_W:0]            jp1;
  logic [IDX_W-1:0]          j_last;
  cse_pkg::bank_t            eval_bank;

  cse_ram #(
    .WIDTH  (DATA_W),
    .DEPTH  (cse_pkg::RAM_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_s   = $signed(ram_rdata);
  assign mul_p  = mul_a * mul_b;
  assign jp1    = {1'b0, j_r} + (IDX_W + 1)'(1);
  assign j_last = IDX_W'(cfg_i.n - CNT_W'(1));

  assign t_calc = T_W'(cmd_i.x) + T_W'(cmd_i.x) - T_W'(cfg_i.lower) - T_W'(cfg_i.upper);
  assign out_of_range = ((cmd_i.x < cfg_i.lower) && (cmd_i.x < cfg_i.upper)) ||
                        ((cmd_i.x > cfg_i.lower) && (cmd_i.x > cfg_i.upper));

  assign ev_sum = (j_r == '0) ?
    SUM_W'(prod_r >>> FB) - SUM_W'(dd_r) + SUM_W'(rd_s >>> 1) :
    SUM_W'(prod_r >>> (FB - 1)) - SUM_W'(dd_r) + SUM_W'(rd_s);
  assign dv_sum = SUM_W'(u2_r) + SUM_W'(prod_r);
  assign scaled = cse_pkg::sat_data(SUM_W'(prod_r >>> FB));

  always_comb begin
    case (cmd_i.ord)
      cse_pkg::ORD_FUNC:  eval_bank = cse_pkg::BANK_COEFF;
      cse_pkg::ORD_FIRST: eval_bank = cse_pkg::BANK_D1;
      default:            eval_bank = cse_pkg::BANK_D2;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    j_nxt         = j_r;
    first_nxt     = first_r;
    t_nxt         = t_r;
    y_nxt         = y_r;
    d_nxt         = d_r;
    dd_nxt        = dd_r;
    u1_nxt        = u1_r;
    u2_nxt        = u2_r;
    res_value_nxt = res_value_r;
    res_error_nxt = res_error_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = cse_pkg::mem_addr(bank_r, j_r);
    mul_a         = '0;
    mul_b         = '0;

    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          res_value_nxt = '0;
          res_error_nxt = 1'b0;
          case (cmd_i.op)
            cse_pkg::OP_WRITE: begin
              if (int'(cmd_i.idx) < cse_pkg::MAX_COEFFS) begin
                ram_we    = 1'b1;
                ram_waddr = cse_pkg::mem_addr(cse_pkg::BANK_COEFF, IDX_W'(cmd_i.idx));
                ram_wdata = cmd_i.value;
              end
              state_nxt = ST_RES;
            end
            cse_pkg::OP_DERIVE: begin
              bank_nxt  = cse_pkg::BANK_COEFF;
              j_nxt     = j_last;
              first_nxt = 1'b1;
              u1_nxt    = '0;
              u2_nxt    = '0;
              state_nxt = ST_DV_MUL;
            end
            cse_pkg::OP_EVAL: begin
              if (out_of_range) begin
                res_error_nxt = 1'b1;
                state_nxt     = ST_RES;
              end else begin
                t_nxt     = t_calc[MUL_W-1:0];
                bank_nxt  = eval_bank;
                state_nxt = ST_MAP_MUL;
              end
            end
            default: begin
              state_nxt = ST_RES;
            end
          endcase
        end
      end
      ST_MAP_MUL: begin
        mul_a     = t_r;
        mul_b     = MUL_W'(cfg_i.scale);
        state_nxt = ST_MAP_Y;
      end
      ST_MAP_Y: begin
        y_nxt     = cse_pkg::sat_data(SUM_W'(prod_r >>> (FB + 1)));
        j_nxt     = j_last;
        d_nxt     = '0;
        dd_nxt    = '0;
        state_nxt = ST_EV_MUL;
      end
      ST_EV_MUL: begin
        mul_a     = MUL_W'(y_r);
        mul_b     = MUL_W'(d_r);
        ram_re    = 1'b1;
        state_nxt = ST_EV_ACC;
      end
      ST_EV_ACC: begin
        if (j_r == '0) begin
          res_value_nxt = cse_pkg::sat_data(ev_sum);
          state_nxt     = ST_RES;
        end else begin
          d_nxt     = cse_pkg::sat_data(ev_sum);
          dd_nxt    = d_r;
          j_nxt     = j_r - IDX_W'(1);
          state_nxt = ST_EV_MUL;
        end
      end
      ST_DV_MUL: begin
        // factor 2(j+1) times src[j+1]; retire previous scaled term
        mul_a = MUL_W'({jp1, 1'b0});
        mul_b = MUL_W'(rd_s);
        if (!first_r) begin
          ram_we    = 1'b1;
          ram_waddr = cse_pkg::mem_addr(bank_r + 2'd1, IDX_W'(jp1));
          ram_wdata = scaled;
        end
        state_nxt = ST_DV_ACC;
      end
      ST_DV_ACC: begin
        u1_nxt    = first_r ? '0 : cse_pkg::sat_data(dv_sum);
        u2_nxt    = u1_r;
        state_nxt = ST_DV_SCL;
      end
      ST_DV_SCL: begin
        mul_a     = MUL_W'(u1_r);
        mul_b     = MUL_W'(cfg_i.scale);
        ram_re    = 1'b1;
        first_nxt = 1'b0;
        if (j_r == '0) begin
          state_nxt = ST_DV_WR;
        end else begin
          j_nxt     = j_r - IDX_W'(1);
          state_nxt = ST_DV_MUL;
        end
      end
      ST_DV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cse_pkg::mem_addr(bank_r + 2'd1, '0);
        ram_wdata = scaled;
        if (bank_r == cse_pkg::BANK_COEFF) begin
          bank_nxt  = cse_pkg::BANK_D1;
          j_nxt     = j_last;
          first_nxt = 1'b1;
          u1_nxt    = '0;
          u2_nxt    = '0;
          state_nxt = ST_DV_MUL;
        end else begin
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        if (take_i) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r      <= bank_nxt;
    j_r         <= j_nxt;
    first_r     <= first_nxt;
    t_r         <= t_nxt;
    y_r         <= y_nxt;
    d_r         <= d_nxt;
    dd_r        <= dd_nxt;
    u1_r        <= u1_nxt;
    u2_r        <= u2_nxt;
    prod_r      <= mul_p;
    res_value_r <= res_value_nxt;
    res_error_r <= res_error_nxt;
  end

  assign idle_o      = (state_r == ST_IDLE);
  assign res_valid_o = (state_r == ST_RES);
  assign res_o.value = res_value_r;
  assign res_o.error = res_error_r;

  `CSE_ASSERT_SAME(a_we_slot, ram_we,
    (state_r == ST_IDLE) || (state_r == ST_DV_MUL) || (state_r == ST_DV_WR),
    "store written outside a write slot")
  `CSE_ASSERT_SAME(a_derive_bank, ram_we && (state_r != ST_IDLE),
    ram_waddr >= ADDR_W'(cse_pkg::MAX_COEFFS), "derive pass wrote the coefficient bank")
  `CSE_ASSERT_SAME(a_index_bound, (state_r == ST_EV_MUL) || (state_r == ST_DV_SCL),
    CNT_W'(j_r) < cfg_i.n, "loop index beyond series length")
  `CSE_ASSERT_NEXT(a_start_busy, start_i && (state_r == ST_IDLE), state_r != ST_IDLE,
    "accepted command left the engine idle")
  `CSE_ASSERT_NEXT(a_res_hold, (state_r == ST_RES) && !take_i,
    (state_r == ST_RES) && $stable(res_value_r) && $stable(res_error_r),
    "pending result changed before transfer")

endmodule

`default_nettype wire

[rtl/chebyshev_series_evaluator.sv]
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator
// Q16.16 Chebyshev series engine: coefficient store, derivative tables,
// Clenshaw evaluation over one shared multiplier and one coefficient RAM.
// ----------------------------------------------------------------------------
// One item in flight; the next is accepted once the result moves to the output
// register. Evaluate is bound by the multiply-then-accumulate Clenshaw loop.
// rst_n (synchronous, active low) idles the sequencer, empties the output and
// restores the registers; coefficient tables stay undefined until written.
`default_nettype none

module chebyshev_series_evaluator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // tdata: coeff_index[4:0], coeff_value[36:5], x_value[68:37],
  //        deriv_order[70:69], zero pad[71]
  input  wire logic [cse_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: op[1:0]
  input  wire logic [cse_pkg::OP_W-1:0]         in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // tdata: result_value[31:0]
  output logic [cse_pkg::DATA_W-1:0]            out_tdata,
  // tuser: range_error[0]
  output logic                                  out_tuser,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cse_pkg::DATA_W-1:0]       cfg_data
);

  localparam int DATA_W  = cse_pkg::DATA_W;
  localparam int CNT_W   = cse_pkg::CNT_W;
  localparam int COUNT_W = cse_pkg::COUNT_W;

  logic signed [DATA_W-1:0] lower_r, upper_r, scale_r;
  logic [COUNT_W-1:0]       count_r;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0]        out_tdata_r;
  logic                     out_tuser_r;

  cse_pkg::cmd_t cmd;
  cse_pkg::cfg_t cfg;
  cse_pkg::res_t res;
  logic          eng_idle, res_valid, res_take, start;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= cse_pkg::LOWER_RST;
      upper_r <= cse_pkg::UPPER_RST;
      scale_r <= cse_pkg::SCALE_RST;
      count_r <= cse_pkg::COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        cse_pkg::REG_LOWER: lower_r <= $signed(cfg_data);
        cse_pkg::REG_UPPER: upper_r <= $signed(cfg_data);
        cse_pkg::REG_SCALE: scale_r <= $signed(cfg_data);
        cse_pkg::REG_COUNT: count_r <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.lower = lower_r;
    cfg.upper = upper_r;
    cfg.scale = scale_r;
    if (count_r < COUNT_W'(2)) begin
      cfg.n = CNT_W'(2);
    end else if (int'(count_r) > cse_pkg::MAX_COEFFS) begin
      cfg.n = CNT_W'(cse_pkg::MAX_COEFFS);
    end else begin
      cfg.n = CNT_W'(count_r);
    end
  end

  assign cmd.op    = in_tuser;
  assign cmd.idx   = in_tdata[cse_pkg::TD_IDX_LSB +: cse_pkg::CIDX_W];
  assign cmd.value = $signed(in_tdata[cse_pkg::TD_VAL_LSB +: DATA_W]);
  assign cmd.x     = $signed(in_tdata[cse_pkg::TD_X_LSB +: DATA_W]);
  assign cmd.ord   = in_tdata[cse_pkg::TD_ORD_LSB +: cse_pkg::ORD_W];

  assign in_tready = eng_idle;
  assign start     = in_tvalid && eng_idle;

  cse_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .idle_o      (eng_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .take_i      (res_take)
  );

  assign res_take       = res_valid && (!out_tvalid_r || out_tready);
  assign out_tvalid_nxt = res_take || (out_tvalid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_tdata_r <= res.value;
      out_tuser_r <= res.error;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for chebyshev_series_evaluator. A directed table covers
// range errors, saturation, the ignored op and derivative order aliasing.
// Random command streams then run under nine interval/length settings.
// Results are checked against a bit-accurate Q16.16 Clenshaw predictor, or against a fixed directed row's value.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    cse_pkg::cmd_t cmd;
    logic          fixed;
    cse_pkg::res_t want;
  } step_t;

  localparam logic [cse_pkg::OP_W-1:0]  OP_NONE    = 2'd3;
  localparam logic [cse_pkg::ORD_W-1:0] ORD_SECOND = 2'd2;
  localparam logic [cse_pkg::ORD_W-1:0] ORD_ALIAS  = 2'd3;

  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 139;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 250;
  localparam int DIRECTED_ROWS = 22;

  // reset settings: a = -1.0, b = 1.0, scale = 1.0, n = 2
  localparam step_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'h7FFF_FFFF, cse_pkg::ORD_FUNC}, 1'b1, '{32'h0, 1'b1}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'h8000_0000, ORD_ALIAS}, 1'b1, '{32'h0, 1'b1}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'h0001_0001, cse_pkg::ORD_FIRST}, 1'b1, '{32'h0, 1'b1}},
    '{'{OP_NONE, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ORD_ALIAS}, 1'b1, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_WRITE, 5'd0, 32'h7FFF_FFFF, 32'h0, cse_pkg::ORD_FUNC}, 1'b1, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_WRITE, 5'd1, 32'h8000_0000, 32'h0, cse_pkg::ORD_FUNC}, 1'b1, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'hFFFF_0000, cse_pkg::ORD_FUNC}, 1'b0, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'h0001_0000, cse_pkg::ORD_FUNC}, 1'b0, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_DERIVE, 5'd0, 32'h0, 32'h0, cse_pkg::ORD_FUNC}, 1'b1, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'h0, cse_pkg::ORD_FIRST}, 1'b0, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'h0001_0000, ORD_SECOND}, 1'b0, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_WRITE, 5'd0, 32'h0002_0000, 32'h0, cse_pkg::ORD_FUNC}, 1'b1, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_WRITE, 5'd1, 32'h0000_8000, 32'h0, cse_pkg::ORD_FUNC}, 1'b1, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'h0, cse_pkg::ORD_FUNC}, 1'b0, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'h0000_8000, cse_pkg::ORD_FUNC}, 1'b0, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_DERIVE, 5'd0, 32'h0, 32'h0, cse_pkg::ORD_FUNC}, 1'b1, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'h0000_4000, cse_pkg::ORD_FIRST}, 1'b0, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'hFFFF_C000, ORD_SECOND}, 1'b0, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'hFFFF_0000, ORD_ALIAS}, 1'b0, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_WRITE, 5'd31, 32'h5555_5555, 32'h0, cse_pkg::ORD_FUNC}, 1'b1, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_WRITE, 5'd30, 32'hAAAA_AAAA, 32'h0, cse_pkg::ORD_FUNC}, 1'b1, '{32'h0, 1'b0}},
    '{'{cse_pkg::OP_EVAL, 5'd0, 32'h0, 32'hFFFE_FFFF, cse_pkg::ORD_FUNC}, 1'b1, '{32'h0, 1'b1}}
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [cse_pkg::IN_TDATA_W-1:0] in_tdata;
  logic [cse_pkg::OP_W-1:0]       in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [cse_pkg::DATA_W-1:0]     out_tdata;
  logic                           out_tuser;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cse_pkg::DATA_W-1:0]     cfg_data;

  // predictor state
  longint                         lower_q;
  longint                         upper_q;
  longint                         scale_q;
  int                             count_q;
  longint                         tbl [cse_pkg::BANKS][cse_pkg::MAX_COEFFS];
  logic [cse_pkg::MAX_COEFFS-1:0] written [cse_pkg::BANKS];

  cse_pkg::res_t pending_results [$];
  int            errors;
  int            results_seen;
  int            tx_idle_pct;
  int            rx_idle_pct;

  chebyshev_series_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clip32(wide_t v);
    if (v > 96'sd2147483647) return 64'sd2147483647;
    if (v < -96'sd2147483648) return -64'sd2147483648;
    return longint'(v);
  endfunction

  function automatic int series_len();
    if (count_q < 2) return 2;
    if (count_q > cse_pkg::MAX_COEFFS) return cse_pkg::MAX_COEFFS;
    return count_q;
  endfunction

  function automatic logic [cse_pkg::MAX_COEFFS-1:0] need_mask(int n, int first);
    logic [cse_pkg::MAX_COEFFS-1:0] m;
    m = '0;
    for (int i = first; i < n; i++) m[i] = 1'b1;
    return m;
  endfunction

  // backward recurrence, then scaling by scale_q
  function automatic void derive_bank(cse_pkg::bank_t src, cse_pkg::bank_t dst, int n);
    tbl[dst][n-1] = 0;
    tbl[dst][n-2] = clip32(wide_t'(2 * (n - 1)) * wide_t'(tbl[src][n-1]));
    for (int j = n - 3; j >= 0; j--)
      tbl[dst][j] = clip32(wide_t'(tbl[dst][j+2]) +
                           wide_t'(2 * (j + 1)) * wide_t'(tbl[src][j+1]));
    for (int j = 0; j < n; j++)
      tbl[dst][j] = clip32((wide_t'(tbl[dst][j]) * wide_t'(scale_q)) >>> cse_pkg::FRAC_BITS);
    written[dst] |= need_mask(n, 0);
  endfunction

  function automatic longint clenshaw_sum(cse_pkg::bank_t b, longint y, int n);
    longint d;
    longint dd;
    longint sv;
    d  = 0;
    dd = 0;
    for (int j = n - 1; j >= 1; j--) begin
      sv = d;
      d  = clip32(((wide_t'(y) * wide_t'(d)) >>> (cse_pkg::FRAC_BITS - 1)) - wide_t'(dd) +
                  wide_t'(tbl[b][j]));
      dd = sv;
    end
    return clip32(((wide_t'(y) * wide_t'(d)) >>> cse_pkg::FRAC_BITS) - wide_t'(dd) +
                  wide_t'(tbl[b][0] >>> 1));
  endfunction

  function automatic cse_pkg::res_t predict_series_result(cse_pkg::cmd_t c);
    cse_pkg::res_t  r;
    int             n;
    longint         x;
    longint         y;
    cse_pkg::bank_t b;
    r = '0;
    n = series_len();
    case (c.op)
      cse_pkg::OP_WRITE: begin
        tbl[cse_pkg::BANK_COEFF][c.idx]     = longint'(c.value);
        written[cse_pkg::BANK_COEFF][c.idx] = 1'b1;
      end
      cse_pkg::OP_DERIVE: begin
        derive_bank(cse_pkg::BANK_COEFF, cse_pkg::BANK_D1, n);
        derive_bank(cse_pkg::BANK_D1, cse_pkg::BANK_D2, n);
      end
      cse_pkg::OP_EVAL: begin
        x = longint'(c.x);
        if ((x < lower_q && x < upper_q) || (x > lower_q && x > upper_q)) begin
          r.error = 1'b1;
        end else begin
          b = (c.ord == cse_pkg::ORD_FUNC) ? cse_pkg::BANK_COEFF :
              (c.ord == cse_pkg::ORD_FIRST) ? cse_pkg::BANK_D1 : cse_pkg::BANK_D2;
          y = clip32((wide_t'(2 * x - lower_q - upper_q) * wide_t'(scale_q))
                     >>> (cse_pkg::FRAC_BITS + 1));
          r.value = cse_pkg::DATA_W'(clenshaw_sum(b, y, n));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random command; reads of never-written table entries are turned into
  // the derive or coefficient write that fills them
  function automatic cse_pkg::cmd_t make_cmd();
    cse_pkg::cmd_t                  c;
    int                             pick;
    int                             n;
    longint                         lo;
    longint                         hi;
    longint                         xv;
    logic                           outside;
    logic [cse_pkg::MAX_COEFFS-1:0] need;
    logic [63:0]                    r64;
    n  = series_len();
    lo = (lower_q < upper_q) ? lower_q : upper_q;
    hi = (lower_q < upper_q) ? upper_q : lower_q;
    c.idx   = cse_pkg::CIDX_W'($urandom_range(cse_pkg::MAX_COEFFS - 1));
    c.value = ($urandom_range(3) == 0) ? cse_pkg::DATA_W'($urandom) :
              cse_pkg::DATA_W'(int'($urandom_range(524288)) - 262144);
    c.x     = cse_pkg::DATA_W'($urandom);
    c.ord   = cse_pkg::ORD_W'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 4) c.op = OP_NONE;
    else if (pick < 40) c.op = cse_pkg::OP_WRITE;
    else if (pick < 50) c.op = cse_pkg::OP_DERIVE;
    else c.op = cse_pkg::OP_EVAL;

    xv   = longint'(c.x);
    pick = $urandom_range(99);
    r64  = {$urandom, $urandom};
    if (pick < 8) xv = lo;
    else if (pick < 16) xv = hi;
    else if (pick < 86) xv = lo + longint'(r64 % (hi - lo + 1));
    else if (pick < 92 && hi < 64'sd2147483647) xv = hi + 1;
    else if (pick < 98 && lo > -64'sd2147483648) xv = lo - 1;
    c.x = cse_pkg::DATA_W'(xv);
    outside = (xv < lo) || (xv > hi);

    if (c.op == cse_pkg::OP_EVAL && !outside && c.ord != cse_pkg::ORD_FUNC &&
        (written[(c.ord == cse_pkg::ORD_FIRST) ? cse_pkg::BANK_D1 : cse_pkg::BANK_D2] &
         need_mask(n, 0)) != need_mask(n, 0))
      c.op = cse_pkg::OP_DERIVE;
    need = '0;
    if (c.op == cse_pkg::OP_DERIVE) need = need_mask(n, 1);
    else if (c.op == cse_pkg::OP_EVAL && !outside && c.ord == cse_pkg::ORD_FUNC)
      need = need_mask(n, 0);
    need &= ~written[cse_pkg::BANK_COEFF];
    if (need != '0) begin
      c.op = cse_pkg::OP_WRITE;
      for (int i = cse_pkg::MAX_COEFFS - 1; i >= 0; i--)
        if (need[i]) c.idx = cse_pkg::CIDX_W'(i);
    end
    return c;
  endfunction

  task automatic flag(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_result(input logic [cse_pkg::DATA_W-1:0] value, input logic error);
    cse_pkg::res_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      flag($sformatf("result %0d unexpected: value %h error %b", results_seen, value, error));
    end else begin
      want = pending_results.pop_front();
      if (value !== want.value)
        flag($sformatf("result %0d value %h, expected %h", results_seen, value, want.value));
      if (error !== want.error)
        flag($sformatf("result %0d range_error %b, expected %b", results_seen, error,
                       want.error));
    end
  endtask

  task automatic send_cmd(input cse_pkg::cmd_t c, input logic fixed, input cse_pkg::res_t want);
    cse_pkg::res_t r;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cse_pkg::IN_TDATA_W'({c.ord, c.x, c.value, c.idx});
    in_tuser  <= c.op;
    do @(posedge clk); while (!in_tready);
    r = predict_series_result(c);
    pending_results.push_back(fixed ? want : r);
  endtask

  task automatic park_sender();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cse_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cse_pkg::DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cse_pkg::REG_LOWER: lower_q = longint'($signed(data));
      cse_pkg::REG_UPPER: upper_q = longint'($signed(data));
      cse_pkg::REG_SCALE: scale_q = longint'($signed(data));
      cse_pkg::REG_COUNT: count_q = int'(data[cse_pkg::COUNT_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_interval(input int p);
    logic [cse_pkg::DATA_W-1:0] a;
    logic [cse_pkg::DATA_W-1:0] b;
    logic [cse_pkg::DATA_W-1:0] s;
    logic [cse_pkg::DATA_W-1:0] k;
    longint                     span;
    case (p)
      1: begin a = 32'hFFFC_0000; b = 32'h0004_0000; s = 32'h0000_4000; k = 32'd8;  end
      2: begin a = 32'h8000_0000; b = 32'h7FFF_FFFF; s = 32'h0000_0002; k = 32'd32; end
      // reversed interval, n below the floor
      3: begin a = 32'h0002_0000; b = 32'hFFFE_0000; s = 32'hFFFF_8000; k = 32'd0;  end
      // single point, n = 63 clamps
      4: begin a = 32'h0000_0000; b = 32'h0000_0000; s = 32'h7FFF_FFFF; k = 32'hFFFF_FFFF; end
      5: begin a = 32'hFFFF_8000; b = 32'h0003_8000; s = 32'h0000_8000; k = 32'd1;  end
      6: begin a = 32'hFFFF_0000; b = 32'h0001_0000; s = 32'h8000_0000; k = 32'd17; end
      7: begin
        span = longint'($urandom_range(16 * 65536, 16384));
        a    = cse_pkg::DATA_W'(-longint'($urandom_range(8 * 65536)));
        b    = cse_pkg::DATA_W'(longint'($signed(a)) + span);
        s    = cse_pkg::DATA_W'((64'sd2 <<< 32) / span);
        k    = cse_pkg::DATA_W'($urandom_range(cse_pkg::MAX_COEFFS, 2));
      end
      default: begin a = $urandom; b = $urandom; s = $urandom; k = $urandom; end
    endcase
    write_reg(cse_pkg::REG_LOWER, a);
    write_reg(cse_pkg::REG_UPPER, b);
    write_reg(cse_pkg::REG_SCALE, s);
    write_reg(cse_pkg::REG_COUNT, k);
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata, out_tuser);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    cse_pkg::cmd_t c;
    int            done;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    errors       = 0;
    results_seen = 0;
    tx_idle_pct  = 33;
    rx_idle_pct  = 84;
    lower_q      = longint'(cse_pkg::LOWER_RST);
    upper_q      = longint'(cse_pkg::UPPER_RST);
    scale_q      = longint'(cse_pkg::SCALE_RST);
    count_q      = int'(cse_pkg::COUNT_RST);
    for (int i = 0; i < cse_pkg::BANKS; i++) written[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_cmd(DIRECTED[i].cmd, DIRECTED[i].fixed, DIRECTED[i].want);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        tx_idle_pct = 84;
        rx_idle_pct = 33;
      end
      if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      park_sender();
      wait_drained();
      if (p > 0) set_interval(p);
      done = 0;
      while (done < PHASE_ITEMS) begin
        c = make_cmd();
        if (c.op != OP_NONE) done++;
        send_cmd(c, 1'b0, '0);
        if ($urandom_range(149) == 0) begin
          park_sender();
          wait_drained();
        end
      end
    end

    park_sender();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/cse_pkg.sv
rtl/cse_ram.sv
rtl/cse_engine.sv
rtl/chebyshev_series_evaluator.sv
dv/tb.sv
